### design/mse_pkg.sv
`default_nettype none

package mse_pkg;

    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 16;
    localparam int SYM_CNT_W   = 3;
    localparam int PATTERN_W   = 5;
    localparam int STEP_W      = 4;
    localparam int CFG_INDEX_W = 8;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 24;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LEN_W-1:0] DOT_RESET       = 16'd200;
    localparam logic [LEN_W-1:0] DASH_RESET      = 16'd600;
    localparam logic [LEN_W-1:0] SYM_GAP_RESET   = 16'd200;
    localparam logic [LEN_W-1:0] CHAR_GAP_RESET  = 16'd600;

    localparam logic [CFG_INDEX_W-1:0] REG_DOT_LENGTH        = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DASH_LENGTH       = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_GAP_LENGTH = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CHAR_GAP_LENGTH   = 8'd3;

    localparam logic [CHAR_W-1:0] CODE_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CODE_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CODE_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CODE_DIGIT_9 = 8'h39;
    localparam logic [5:0]        DIGIT_BASE   = 6'd26;

    typedef struct packed {
        logic [SYM_CNT_W-1:0] sym_count;
        logic [PATTERN_W-1:0] pattern;
    } mse_entry_t;

    typedef struct packed {
        logic [LEN_W-1:0] dot_length;
        logic [LEN_W-1:0] dash_length;
        logic [LEN_W-1:0] symbol_gap_length;
        logic [LEN_W-1:0] char_gap_length;
    } mse_cfg_t;

    // symbol count in [7:5], pattern in [4:0], first symbol highest, 1 = dash
    function automatic logic [7:0] morse_entry(input logic [5:0] idx);
        logic [7:0] e;
        case (idx)
            6'd0:  e = {3'd2, 5'd1};
            6'd1:  e = {3'd4, 5'd8};
            6'd2:  e = {3'd4, 5'd10};
            6'd3:  e = {3'd3, 5'd4};
            6'd4:  e = {3'd1, 5'd0};
            6'd5:  e = {3'd4, 5'd2};
            6'd6:  e = {3'd3, 5'd6};
            6'd7:  e = {3'd4, 5'd0};
            6'd8:  e = {3'd2, 5'd0};
            6'd9:  e = {3'd4, 5'd7};
            6'd10: e = {3'd3, 5'd5};
            6'd11: e = {3'd4, 5'd4};
            6'd12: e = {3'd2, 5'd3};
            6'd13: e = {3'd2, 5'd2};
            6'd14: e = {3'd3, 5'd7};
            6'd15: e = {3'd4, 5'd6};
            6'd16: e = {3'd4, 5'd13};
            6'd17: e = {3'd3, 5'd2};
            6'd18: e = {3'd3, 5'd0};
            6'd19: e = {3'd1, 5'd1};
            6'd20: e = {3'd3, 5'd1};
            6'd21: e = {3'd4, 5'd1};
            6'd22: e = {3'd3, 5'd3};
            6'd23: e = {3'd4, 5'd9};
            6'd24: e = {3'd4, 5'd11};
            6'd25: e = {3'd4, 5'd12};
            6'd26: e = {3'd5, 5'd31};
            6'd27: e = {3'd5, 5'd15};
            6'd28: e = {3'd5, 5'd7};
            6'd29: e = {3'd5, 5'd3};
            6'd30: e = {3'd5, 5'd1};
            6'd31: e = {3'd5, 5'd0};
            6'd32: e = {3'd5, 5'd16};
            6'd33: e = {3'd5, 5'd24};
            6'd34: e = {3'd5, 5'd28};
            6'd35: e = {3'd5, 5'd30};
            default: e = 8'd0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

### design/mse_front.sv
`default_nettype none

module mse_front
    import mse_pkg::*;
(
    input  wire logic [CHAR_W-1:0] char_code,
    output mse_entry_t             entry
);

    logic [7:0]           tab_word;
    logic [5:0]           tab_idx;
    logic                 known;
    logic [SYM_CNT_W-1:0] cnt;
    logic [PATTERN_W-1:0] pat;

    always_comb
    begin
        tab_idx = 6'd0;
        known   = 1'b0;
        if (char_code inside {[CODE_UPPER_A:CODE_UPPER_Z]})
        begin
            tab_idx = 6'(char_code - CODE_UPPER_A);
            known   = 1'b1;
        end
        else if (char_code inside {[CODE_DIGIT_0:CODE_DIGIT_9]})
        begin
            tab_idx = 6'(char_code - CODE_DIGIT_0) + DIGIT_BASE;
            known   = 1'b1;
        end
        tab_word = morse_entry(tab_idx);
        cnt      = known ? tab_word[7:5] : '0;
        pat      = tab_word[4:0];
        // left-align: first symbol lands in the top bit
        entry.sym_count = cnt;
        entry.pattern   = PATTERN_W'(pat << (3'(PATTERN_W) - cnt));
    end

endmodule

`default_nettype wire

### design/mse_queue.sv
`default_nettype none

module mse_queue
    import mse_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire mse_entry_t push_entry,
    output logic            full,
    input  wire logic       pop,
    output mse_entry_t      head,
    output logic            not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mse_entry_t       store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = store_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### design/mse_back.sv
`default_nettype none

module mse_back
    import mse_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mse_cfg_t         cfg,
    input  wire mse_entry_t       head,
    input  wire logic             head_valid,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  led_level,
    output logic [LEN_W-1:0]      segment_length,
    output logic                  end_of_char
);

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    state_t               state_reg;
    logic [SYM_CNT_W-1:0] count_reg;
    logic [PATTERN_W-1:0] pat_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 valid_reg;
    logic                 led_reg;
    logic [LEN_W-1:0]     length_reg;
    logic                 last_reg;
    logic                 load;
    logic                 seg_last;
    logic                 seg_on;

    assign pop      = (state_reg == ST_IDLE) && head_valid;
    assign load     = (state_reg == ST_SEND) && (!valid_reg || out_ready);
    assign seg_last = (step_reg == {count_reg, 1'b0});
    assign seg_on   = !seg_last && !step_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            pat_reg    <= '0;
            step_reg   <= '0;
            valid_reg  <= 1'b0;
            led_reg    <= 1'b0;
            length_reg <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (valid_reg && out_ready)
                    begin
                        valid_reg <= 1'b0;
                    end
                    if (pop)
                    begin
                        count_reg <= head.sym_count;
                        pat_reg   <= head.pattern;
                        step_reg  <= '0;
                        state_reg <= ST_SEND;
                    end
                end
                ST_SEND:
                begin
                    if (load)
                    begin
                        valid_reg <= 1'b1;
                        last_reg  <= seg_last;
                        led_reg   <= seg_on;
                        if (seg_last)
                        begin
                            length_reg <= cfg.char_gap_length;
                            state_reg  <= ST_IDLE;
                        end
                        else if (seg_on)
                        begin
                            length_reg <= pat_reg[PATTERN_W-1] ? cfg.dash_length
                                                               : cfg.dot_length;
                            pat_reg    <= {pat_reg[PATTERN_W-2:0], 1'b0};
                        end
                        else
                        begin
                            length_reg <= cfg.symbol_gap_length;
                        end
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = valid_reg;
    assign led_level      = led_reg;
    assign segment_length = length_reg;
    assign end_of_char    = last_reg;

endmodule

`default_nettype wire

### design/morse_segment_encoder_top.sv
// Morse segment encoder.
// Input stream: one character code per request in s_tdata[7:0]. A-Z and 0-9
// are encoded; every other code is sent as a space.
// Output stream: one LED segment per request. m_tdata[0] is the LED level,
// m_tdata[16:1] the segment length in milliseconds, m_tlast marks the closing
// character-gap segment. A character of n symbols gives 2n+1 segments.
// Configuration: cfg_index 0..3 selects dot, dash, symbol gap and character
// gap length; other indexes are ignored. cfg_ready is always high.
// With the sequencer idle, an accepted character is written into the queue,
// then popped into the sequencer, which loads its first segment into the
// output register. While m_tready is high the sequencer sends one segment per
// cycle; after the closing segment it returns to idle to fetch the next entry
// from the character queue.
// The queue holds QUEUE_DEPTH classified characters; s_tready drops when full.
// Reset clears the queue and sequencer and loads the lengths 200, 600, 200
// and 600. When m_tready is low the output register holds its segment and the
// sequencer stalls; the queue keeps taking characters until it fills.
`default_nettype none

module morse_segment_encoder_top
    import mse_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [TDATA_IN_W-1:0]  s_tdata,   // [7:0] char_code
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [TDATA_OUT_W-1:0]      m_tdata,   // [0] led_level, [16:1] segment_length
    output logic                        m_tlast,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]       cfg_data
);

    mse_cfg_t         cfg_reg;
    mse_entry_t       front_entry;
    mse_entry_t       q_head;
    logic             q_full;
    logic             q_not_empty;
    logic             q_pop;
    logic             led_level;
    logic [LEN_W-1:0] segment_length;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dot_length        <= DOT_RESET;
            cfg_reg.dash_length       <= DASH_RESET;
            cfg_reg.symbol_gap_length <= SYM_GAP_RESET;
            cfg_reg.char_gap_length   <= CHAR_GAP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DOT_LENGTH:        cfg_reg.dot_length        <= cfg_data;
                REG_DASH_LENGTH:       cfg_reg.dash_length       <= cfg_data;
                REG_SYMBOL_GAP_LENGTH: cfg_reg.symbol_gap_length <= cfg_data;
                REG_CHAR_GAP_LENGTH:   cfg_reg.char_gap_length   <= cfg_data;
                default:               ;
            endcase
        end
    end

    assign s_tready = !q_full;

    mse_front u_front
    (
        .char_code (s_tdata[CHAR_W-1:0]),
        .entry     (front_entry)
    );

    mse_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .not_empty  (q_not_empty)
    );

    mse_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .head           (q_head),
        .head_valid     (q_not_empty),
        .pop            (q_pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .led_level      (led_level),
        .segment_length (segment_length),
        .end_of_char    (m_tlast)
    );

    assign m_tdata = {{(TDATA_OUT_W - LEN_W - 1){1'b0}}, segment_length, led_level};

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench
    import mse_pkg::*;
();

    localparam int DRAIN_CYCLES = 24;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LAST  = 8'hFF;
    localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;

    typedef struct packed {
        logic             led;
        logic [LEN_W-1:0] seg_len;
        logic             closing;
    } segment_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [LEN_W-1:0]       cfg_data;

    logic [LEN_W-1:0] dot_ms;
    logic [LEN_W-1:0] dash_ms;
    logic [LEN_W-1:0] sym_gap_ms;
    logic [LEN_W-1:0] char_gap_ms;

    segment_t pending_segments[$];
    int       mismatch_count;
    bit       idle_on;
    int       hold_request;

    morse_segment_encoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    function automatic string morse_symbols(input logic [CHAR_W-1:0] code);
        int idx;
        idx = -1;
        if (code >= CODE_UPPER_A && code <= CODE_UPPER_Z)
            idx = int'(code) - int'(CODE_UPPER_A);
        else if (code >= CODE_DIGIT_0 && code <= CODE_DIGIT_9)
            idx = int'(code) - int'(CODE_DIGIT_0) + 26;
        case (idx)
            0:  return ".-";
            1:  return "-...";
            2:  return "-.-.";
            3:  return "-..";
            4:  return ".";
            5:  return "..-.";
            6:  return "--.";
            7:  return "....";
            8:  return "..";
            9:  return ".---";
            10: return "-.-";
            11: return ".-..";
            12: return "--";
            13: return "-.";
            14: return "---";
            15: return ".--.";
            16: return "--.-";
            17: return ".-.";
            18: return "...";
            19: return "-";
            20: return "..-";
            21: return "...-";
            22: return ".--";
            23: return "-..-";
            24: return "-.--";
            25: return "--..";
            26: return "-----";
            27: return ".----";
            28: return "..---";
            29: return "...--";
            30: return "....-";
            31: return ".....";
            32: return "-....";
            33: return "--...";
            34: return "---..";
            35: return "----.";
            default: return "";
        endcase
    endfunction

    function automatic void predict_segments(input logic [CHAR_W-1:0] code);
        string    symbols;
        segment_t seg;
        symbols = morse_symbols(code);
        for (int i = 0; i < symbols.len(); i++)
        begin
            seg.led     = 1'b1;
            seg.seg_len = (symbols[i] == "-") ? dash_ms : dot_ms;
            seg.closing = 1'b0;
            pending_segments.push_back(seg);
            seg.led     = 1'b0;
            seg.seg_len = sym_gap_ms;
            pending_segments.push_back(seg);
        end
        seg.led     = 1'b0;
        seg.seg_len = char_gap_ms;
        seg.closing = 1'b1;
        pending_segments.push_back(seg);
    endfunction

    function automatic logic [CHAR_W-1:0] random_char();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 4)
            return CODE_UPPER_A + CHAR_W'($urandom_range(0, 25));
        else if (pick <= 6)
            return CODE_DIGIT_0 + CHAR_W'($urandom_range(0, 9));
        else if (pick == 7)
            return CODE_SPACE;
        else
            return CHAR_W'($urandom_range(0, 255));
    endfunction

    // receiver: random stalls plus a long hold on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        segment_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_segments.size() == 0)
            begin
                $error("segment with nothing pending: tdata=%h tlast=%b", m_tdata, m_tlast);
                mismatch_count++;
            end
            else
            begin
                want = pending_segments.pop_front();
                if (m_tdata[0] !== want.led)
                begin
                    $error("led_level expected %0d actual %0d", want.led, m_tdata[0]);
                    mismatch_count++;
                end
                if (m_tdata[16:1] !== want.seg_len)
                begin
                    $error("segment_length expected %0d actual %0d",
                           want.seg_len, m_tdata[16:1]);
                    mismatch_count++;
                end
                if (m_tlast !== want.closing)
                begin
                    $error("end_of_char expected %0d actual %0d", want.closing, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] code);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        else
            @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        do
            @(posedge clk);
        while (!s_tready);
        predict_segments(code);
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_segments.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [LEN_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            REG_DOT_LENGTH:        dot_ms = value;
            REG_DASH_LENGTH:       dash_ms = value;
            REG_SYMBOL_GAP_LENGTH: sym_gap_ms = value;
            REG_CHAR_GAP_LENGTH:   char_gap_ms = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [LEN_W-1:0] dot, input logic [LEN_W-1:0] dash,
                             input logic [LEN_W-1:0] sgap, input logic [LEN_W-1:0] cgap);
        write_reg(REG_DOT_LENGTH, dot);
        write_reg(REG_DASH_LENGTH, dash);
        write_reg(REG_SYMBOL_GAP_LENGTH, sgap);
        write_reg(REG_CHAR_GAP_LENGTH, cgap);
    endtask

    function automatic logic [LEN_W-1:0] random_length();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return LEN_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic test_reset_lengths();
        send_char("E");
        send_char("T");
        send_char(CODE_SPACE);
        send_char("0");
        send_char("5");
    endtask

    task automatic test_code_boundaries();
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CODE_UPPER_A);
        send_char(CODE_UPPER_Z);
        send_char(CODE_DIGIT_0);
        send_char(CODE_DIGIT_9);
        send_char(CODE_UPPER_A - 8'd1);
        send_char(CODE_UPPER_Z + 8'd1);
        send_char(CODE_DIGIT_0 - 8'd1);
        send_char(CODE_DIGIT_9 + 8'd1);
        send_char("a");
        send_char("z");
        send_char(8'h80);
        send_char(8'h7F);
        send_char("Q");
        send_char("Y");
        wait_quiet();
    endtask

    task automatic test_length_extremes();
        write_all('0, '0, '0, '0);
        send_char("B");
        send_char(CODE_SPACE);
        wait_quiet();
        write_all('1, '1, '1, '1);
        send_char("K");
        send_char("7");
        wait_quiet();
        write_all(16'h0001, 16'h8000, 16'h5555, 16'hAAAA);
        send_char("C");
        send_char("X");
        wait_quiet();
        // writes to unused indexes must leave the lengths alone
        write_reg(REG_UNUSED_FIRST, 16'h1234);
        write_reg(REG_UNUSED_LAST, 16'hFFFF);
        write_reg(CFG_INDEX_W'($urandom_range(4, 254)), LEN_W'($urandom_range(0, 65535)));
        send_char("R");
        send_char("9");
        wait_quiet();
    endtask

    task automatic test_random_traffic(input int phases, input int items_per_phase);
        for (int p = 0; p < phases; p++)
        begin
            write_all(random_length(), random_length(), random_length(), random_length());
            if ($urandom_range(0, 1))
                write_reg(CFG_INDEX_W'($urandom_range(4, 255)),
                          LEN_W'($urandom_range(0, 65535)));
            for (int n = 0; n < items_per_phase; n++)
                send_char(random_char());
            wait_quiet();
        end
    endtask

    task automatic test_backpressure();
        @(negedge clk);
        hold_request = LONG_HOLD_CYCLES;
        for (int n = 0; n < 20; n++)
            send_char(random_char());
        wait_quiet();
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        write_all(random_length(), random_length(), random_length(), random_length());
        for (int n = 0; n < 100; n++)
            send_char(random_char());
        wait_quiet();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mismatch_count = 0;
        hold_request   = 0;
        idle_on        = 1'b1;
        dot_ms         = 16'd200;
        dash_ms        = 16'd600;
        sym_gap_ms     = 16'd200;
        char_gap_ms    = 16'd600;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_lengths();
        test_code_boundaries();
        test_length_extremes();
        test_random_traffic(4, 80);
        test_backpressure();
        test_full_rate();

        wait_quiet();
        if (mismatch_count == 0 && pending_segments.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
